// ===== sv/tpyp_pkg.sv =====
`default_nettype none

package tpyp_pkg;

    localparam int TILE_SIZE_DEF     = 64;
    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int FMT_W     = 3;
    localparam int CH_W      = 13;
    localparam int POS_OUT_W = 6;
    // widest column or row index over the whole tile size range
    localparam int POS_MAX_W = 8;

    localparam int PROD_W = 25;
    localparam int SUM_W  = 27;
    localparam int SHR_W  = 17;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_PALETTE = 2'd1,
        KIND_PAD     = 2'd2
    } kind_t;

    typedef enum logic [FMT_W-1:0] {
        FMT_BGRA    = 3'd0,
        FMT_RGBA    = 3'd1,
        FMT_BGR     = 3'd2,
        FMT_RGB     = 3'd3,
        FMT_BGR565  = 3'd4,
        FMT_RGB565  = 3'd5,
        FMT_PLANAR4 = 3'd6,
        FMT_PAL8    = 3'd7
    } fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_FORMAT = 2'd0,
        REG_TILE_WIDTH    = 2'd1,
        REG_TILE_HEIGHT   = 2'd2
    } reg_idx_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } bk_state_t;

    localparam logic signed [15:0] C_Y_R  =  16'sd9798;
    localparam logic signed [15:0] C_Y_G  =  16'sd19235;
    localparam logic signed [15:0] C_Y_B  =  16'sd3735;
    localparam logic signed [15:0] C_CB_R = -16'sd5535;
    localparam logic signed [15:0] C_CB_G = -16'sd10868;
    localparam logic signed [15:0] C_CB_B =  16'sd16403;
    localparam logic signed [15:0] C_CR_R =  16'sd16377;
    localparam logic signed [15:0] C_CR_G = -16'sd13714;
    localparam logic signed [15:0] C_CR_B = -16'sd2663;

    localparam logic signed [SHR_W-1:0] Y_OFFSET = 17'sd4096;
    localparam logic signed [SHR_W-1:0] LIM_LO   = -17'sd4096;
    localparam logic signed [SHR_W-1:0] LIM_HI   = 17'sd4095;

    localparam logic [BYTE_W-1:0] MASK_565_HI  = 8'hF8;
    localparam logic [BYTE_W-1:0] MASK_565_MID = 8'hE0;

    typedef struct packed {
        logic signed [CH_W-1:0] luma;
        logic signed [CH_W-1:0] cb;
        logic signed [CH_W-1:0] cr;
    } ycc_t;

    typedef struct packed {
        logic                 is_pad;
        logic                 last;
        logic [POS_MAX_W-1:0] col;
        logic [POS_MAX_W-1:0] row;
        ycc_t                 ycc;
    } cmd_t;

    typedef struct packed {
        ycc_t                 ycc;
        logic [POS_OUT_W-1:0] column;
        logic [POS_OUT_W-1:0] row;
        logic                 row_done;
    } result_t;

    function automatic logic signed [PROD_W-1:0] mul_coef(
        input logic [BYTE_W-1:0]  v,
        input logic signed [15:0] c
    );
        return PROD_W'($signed({1'b0, v})) * PROD_W'(c);
    endfunction

endpackage

`default_nettype wire

// ===== sv/tpyp_front.sv =====
`default_nettype none

module tpyp_front #(
    parameter int TILE_SIZE     = tpyp_pkg::TILE_SIZE_DEF,
    parameter int PALETTE_DEPTH = tpyp_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tpyp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpyp_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tpyp_pkg::KIND_W-1:0]    kind,
    input  logic [tpyp_pkg::BYTE_W-1:0]    byte0,
    input  logic [tpyp_pkg::BYTE_W-1:0]    byte1,
    input  logic [tpyp_pkg::BYTE_W-1:0]    byte2,
    input  logic [tpyp_pkg::BYTE_W-1:0]    byte3,
    input  logic [tpyp_pkg::BYTE_W-1:0]    entry_index,
    input  logic [tpyp_pkg::BYTE_W-1:0]    entry_red,
    input  logic [tpyp_pkg::BYTE_W-1:0]    entry_green,
    input  logic [tpyp_pkg::BYTE_W-1:0]    entry_blue,
    input  logic [tpyp_pkg::CQ_CNT_W-1:0]  q_count,
    output logic                           q_push,
    output tpyp_pkg::cmd_t                 q_cmd
);
    import tpyp_pkg::*;

    localparam int COL_W  = $clog2(TILE_SIZE);
    localparam int SZ_W   = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam int IDXC_W = BYTE_W + 1;
    localparam int USED_W = CQ_CNT_W + 1;

    function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_W-1:0] v);
        logic [SZ_W-1:0] ve;
        ve = SZ_W'(v);
        if (v == '0)
            return SZ_W'(1);
        if (ve > SZ_W'(TILE_SIZE))
            return SZ_W'(TILE_SIZE);
        return ve;
    endfunction

    function automatic logic signed [CH_W-1:0] finish_ch(
        input logic signed [PROD_W-1:0] a,
        input logic signed [PROD_W-1:0] b,
        input logic signed [PROD_W-1:0] c,
        input logic                     with_offset
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [SHR_W-1:0] sh;
        sum = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
        sh  = SHR_W'(sum >>> 10);
        if (with_offset)
            sh = sh - Y_OFFSET;
        if (sh < LIM_LO)
            return CH_W'(LIM_LO);
        if (sh > LIM_HI)
            return CH_W'(LIM_HI);
        return CH_W'(sh);
    endfunction

    // configuration
    fmt_t             fmt_reg;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_BGRA;
            width_reg  <= CFG_W'(TILE_SIZE);
            height_reg <= CFG_W'(TILE_SIZE);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOURCE_FORMAT: fmt_reg    <= fmt_t'(cfg_wdata[FMT_W-1:0]);
                REG_TILE_WIDTH:    width_reg  <= cfg_wdata;
                REG_TILE_HEIGHT:   height_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // position counters and item classification
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] row_reg, row_next;
    logic [SZ_W-1:0]  w_eff, h_eff, col_inc;
    logic             acc, row_ok, pix_go, pad_go, row_end, row_wrap;
    logic [USED_W-1:0] used;

    logic s1_valid_reg;
    logic s2_valid_reg;

    always_comb
    begin
        used = USED_W'(q_count) + USED_W'(s1_valid_reg) + USED_W'(s2_valid_reg);
        in_ready = used < USED_W'(CQ_DEPTH);
        acc      = in_valid && in_ready;
        w_eff    = eff_size(width_reg);
        h_eff    = eff_size(height_reg);
        col_inc  = SZ_W'(col_reg) + SZ_W'(1);
        row_ok   = SZ_W'(row_reg) < h_eff;
        pix_go   = acc && (kind == KIND_PIXEL) && row_ok;
        pad_go   = acc && (kind == KIND_PAD) && !row_ok;
        row_end  = col_inc >= w_eff;
        row_wrap = row_reg == COL_W'(TILE_SIZE - 1);
        col_next = col_reg;
        row_next = row_reg;
        if ((pix_go && row_end) || pad_go)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_reg + COL_W'(1);
        end
        else if (pix_go)
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // palette store, written by palette words and read on every accepted word
    logic [2:0]              plane_bit;
    logic [3:0]              planar_idx;
    logic [BYTE_W-1:0]       rd_idx;
    logic                    rd_in_range, wr_in_range, pal_we;
    logic [PAL_AW-1:0]       rd_addr, wr_addr;
    logic [3*BYTE_W-1:0]     pal_mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] pal_vld_reg;
    logic [3*BYTE_W-1:0]     pal_rd_reg;
    logic                    pal_ok_reg;

    always_comb
    begin
        plane_bit   = 3'd7 - col_reg[2:0];
        planar_idx  = {byte3[plane_bit], byte2[plane_bit], byte1[plane_bit], byte0[plane_bit]};
        rd_idx      = (fmt_reg == FMT_PLANAR4) ? BYTE_W'(planar_idx) : byte0;
        rd_in_range = IDXC_W'(rd_idx) < IDXC_W'(PALETTE_DEPTH);
        wr_in_range = IDXC_W'(entry_index) < IDXC_W'(PALETTE_DEPTH);
        rd_addr     = rd_idx[PAL_AW-1:0];
        wr_addr     = entry_index[PAL_AW-1:0];
        pal_we      = acc && (kind == KIND_PALETTE) && wr_in_range;
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
            pal_mem[wr_addr] <= {entry_red, entry_green, entry_blue};
        if (acc)
        begin
            pal_rd_reg <= pal_mem[rd_addr];
            pal_ok_reg <= rd_in_range && pal_vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pal_vld_reg <= '0;
        else if (pal_we)
            pal_vld_reg[wr_addr] <= 1'b1;
    end

    // stage 1: unpack
    logic              s1_pad_reg, s1_last_reg;
    logic [COL_W-1:0]  s1_col_reg, s1_row_reg;
    logic [BYTE_W-1:0] s1_b0_reg, s1_b1_reg, s1_b2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= pix_go || pad_go;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_pad_reg  <= pad_go;
            s1_last_reg <= row_end;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_b0_reg   <= byte0;
            s1_b1_reg   <= byte1;
            s1_b2_reg   <= byte2;
        end
    end

    logic [BYTE_W-1:0]   hi5, mid6, lo5, red, green, blue;
    logic [3*BYTE_W-1:0] pal_rgb;

    always_comb
    begin
        hi5     = (s1_b1_reg & MASK_565_HI) | {5'd0, s1_b1_reg[7:5]};
        mid6    = {s1_b1_reg[2:0], 5'd0} | ((s1_b0_reg & MASK_565_MID) >> 3);
        lo5     = {s1_b0_reg[4:0], s1_b0_reg[4:2]};
        pal_rgb = pal_ok_reg ? pal_rd_reg : '0;
        case (fmt_reg)
            FMT_BGRA, FMT_BGR:
            begin
                red = s1_b2_reg; green = s1_b1_reg; blue = s1_b0_reg;
            end
            FMT_RGBA, FMT_RGB:
            begin
                red = s1_b0_reg; green = s1_b1_reg; blue = s1_b2_reg;
            end
            FMT_BGR565:
            begin
                red = lo5; green = mid6; blue = hi5;
            end
            FMT_RGB565:
            begin
                red = hi5; green = mid6; blue = lo5;
            end
            default:
            begin
                red   = pal_rgb[23:16];
                green = pal_rgb[15:8];
                blue  = pal_rgb[7:0];
            end
        endcase
    end

    // stage 2: matrix products
    logic                    s2_pad_reg, s2_last_reg;
    logic [COL_W-1:0]        s2_col_reg, s2_row_reg;
    logic signed [PROD_W-1:0] yr_reg, yg_reg, yb_reg;
    logic signed [PROD_W-1:0] br_reg, bg_reg, bb_reg;
    logic signed [PROD_W-1:0] rr_reg, rg_reg, rb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_pad_reg  <= s1_pad_reg;
            s2_last_reg <= s1_last_reg;
            s2_col_reg  <= s1_col_reg;
            s2_row_reg  <= s1_row_reg;
            yr_reg <= mul_coef(red, C_Y_R);
            yg_reg <= mul_coef(green, C_Y_G);
            yb_reg <= mul_coef(blue, C_Y_B);
            br_reg <= mul_coef(red, C_CB_R);
            bg_reg <= mul_coef(green, C_CB_G);
            bb_reg <= mul_coef(blue, C_CB_B);
            rr_reg <= mul_coef(red, C_CR_R);
            rg_reg <= mul_coef(green, C_CR_G);
            rb_reg <= mul_coef(blue, C_CR_B);
        end
    end

    // sum, shift, clamp into the queue
    always_comb
    begin
        q_push         = s2_valid_reg;
        q_cmd.is_pad   = s2_pad_reg;
        q_cmd.last     = s2_last_reg;
        q_cmd.col      = POS_MAX_W'(s2_col_reg);
        q_cmd.row      = POS_MAX_W'(s2_row_reg);
        q_cmd.ycc.luma = finish_ch(yr_reg, yg_reg, yb_reg, 1'b1);
        q_cmd.ycc.cb   = finish_ch(br_reg, bg_reg, bb_reg, 1'b0);
        q_cmd.ycc.cr   = finish_ch(rr_reg, rg_reg, rb_reg, 1'b0);
    end

endmodule

`default_nettype wire

// ===== sv/tpyp_cmd_queue.sv =====
`default_nettype none

module tpyp_cmd_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  tpyp_pkg::cmd_t                push_cmd,
    input  logic                          pop,
    output tpyp_pkg::cmd_t                head,
    output logic [tpyp_pkg::CQ_CNT_W-1:0] count
);
    import tpyp_pkg::*;

    cmd_t                mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + CQ_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + CQ_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CQ_CNT_W'(push) - CQ_CNT_W'(pop);
        head        = mem[rd_ptr_reg];
        count       = count_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tpyp_back.sv =====
`default_nettype none

module tpyp_back #(
    parameter int TILE_SIZE = tpyp_pkg::TILE_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tpyp_pkg::CQ_CNT_W-1:0] q_count,
    input  tpyp_pkg::cmd_t                q_head,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tpyp_pkg::result_t             out_word
);
    import tpyp_pkg::*;

    localparam int COL_W  = $clog2(TILE_SIZE);
    localparam int EXT_W  = (COL_W > POS_OUT_W) ? COL_W : POS_OUT_W;
    localparam int USED_W = OQ_CNT_W + 1;

    bk_state_t        state_reg, state_next;
    logic [COL_W-1:0] cur_reg, end_reg, row_reg;
    logic             pad_reg;
    ycc_t             ycc_reg;
    logic             issue, take, at_end;
    logic [USED_W-1:0] used;

    logic                sb_valid_reg;
    logic [OQ_CNT_W-1:0] oq_count_reg, oq_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        used   = USED_W'(oq_count_reg) + USED_W'(sb_valid_reg);
        at_end = cur_reg == end_reg;
        issue  = (state_reg == BK_RUN) && (used < USED_W'(OQ_DEPTH));
        take   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                take = q_count != '0;
                if (take)
                    state_next = BK_RUN;
            end
            BK_RUN:
            begin
                if (issue && at_end)
                begin
                    take = q_count != '0;
                    if (!take)
                        state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        q_pop = take;
    end

    // current run: one column per issued word
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_reg <= q_head.is_pad ? '0 : q_head.col[COL_W-1:0];
            end_reg <= (q_head.is_pad || q_head.last) ? COL_W'(TILE_SIZE - 1)
                                                      : q_head.col[COL_W-1:0];
            row_reg <= q_head.row[COL_W-1:0];
            pad_reg <= q_head.is_pad;
            ycc_reg <= q_head.ycc;
        end
        else if (issue)
        begin
            cur_reg <= cur_reg + COL_W'(1);
        end
    end

    // last row store, written by pixels and replayed by pad rows
    ycc_t                 store_mem [TILE_SIZE];
    logic [TILE_SIZE-1:0] store_vld_reg;
    ycc_t                 store_rd_reg;
    logic                 store_hit_reg;
    logic                 store_we;

    assign store_we = issue && !pad_reg;

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[cur_reg] <= ycc_reg;
        if (issue)
        begin
            store_rd_reg  <= store_mem[cur_reg];
            store_hit_reg <= store_vld_reg[cur_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            store_vld_reg <= '0;
        else if (store_we)
            store_vld_reg[cur_reg] <= 1'b1;
    end

    // read stage
    logic             sb_pad_reg;
    ycc_t             sb_ycc_reg;
    logic [COL_W-1:0] sb_col_reg, sb_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sb_valid_reg <= 1'b0;
        else
            sb_valid_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            sb_pad_reg <= pad_reg;
            sb_ycc_reg <= ycc_reg;
            sb_col_reg <= cur_reg;
            sb_row_reg <= row_reg;
        end
    end

    result_t          sb_word;
    logic [EXT_W-1:0] col_ext, row_ext;

    always_comb
    begin
        col_ext = EXT_W'(sb_col_reg);
        row_ext = EXT_W'(sb_row_reg);
        // never-written store entries read as zero
        if (sb_pad_reg)
            sb_word.ycc = store_hit_reg ? store_rd_reg : '0;
        else
            sb_word.ycc = sb_ycc_reg;
        sb_word.column   = col_ext[POS_OUT_W-1:0];
        sb_word.row      = row_ext[POS_OUT_W-1:0];
        sb_word.row_done = sb_col_reg == COL_W'(TILE_SIZE - 1);
    end

    // output queue parts the sequencer from the consumer
    result_t             oq_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] oq_wr_reg, oq_wr_next;
    logic [OQ_PTR_W-1:0] oq_rd_reg, oq_rd_next;
    logic                oq_pop;

    always_comb
    begin
        out_valid     = oq_count_reg != '0;
        out_word      = oq_mem[oq_rd_reg];
        oq_pop        = out_valid && out_ready;
        oq_wr_next    = sb_valid_reg ? oq_wr_reg + OQ_PTR_W'(1) : oq_wr_reg;
        oq_rd_next    = oq_pop ? oq_rd_reg + OQ_PTR_W'(1) : oq_rd_reg;
        oq_count_next = oq_count_reg + OQ_CNT_W'(sb_valid_reg) - OQ_CNT_W'(oq_pop);
    end

    always_ff @(posedge clk)
    begin
        if (sb_valid_reg)
            oq_mem[oq_wr_reg] <= sb_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            oq_wr_reg    <= oq_wr_next;
            oq_rd_reg    <= oq_rd_next;
            oq_count_reg <= oq_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tile_pixel_to_ycbcr_pad_top.sv =====
`default_nettype none

// channel   direction  handshake              payload
// config    in         cfg_we                 cfg_index, cfg_wdata
// item      in         in_valid / in_ready    kind, byte0..byte3, entry_*
// result    out        out_valid / out_ready  luma, chroma_blue, chroma_red, column, row, row_done
//
// the front takes one word per cycle while its command queue has room and passes it through its
// unpack and matrix-product registers into the queue; the back sends one result word per cycle
// while its output queue has room, so a pixel inside a row yields one word, a row-ending pixel
// one per column up to TILE_SIZE - 1, a pad row TILE_SIZE; palette writes send nothing.
// reset clears counters, queues and the valid bits of both stores at once.
// a stalled out_ready fills the output queue, then the command queue, then drops in_ready.

module tile_pixel_to_ycbcr_pad_top #(
    parameter int TILE_SIZE     = tpyp_pkg::TILE_SIZE_DEF,
    parameter int PALETTE_DEPTH = tpyp_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tpyp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpyp_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tpyp_pkg::KIND_W-1:0]    kind,
    input  logic [tpyp_pkg::BYTE_W-1:0]    byte0,
    input  logic [tpyp_pkg::BYTE_W-1:0]    byte1,
    input  logic [tpyp_pkg::BYTE_W-1:0]    byte2,
    input  logic [tpyp_pkg::BYTE_W-1:0]    byte3,
    input  logic [tpyp_pkg::BYTE_W-1:0]    entry_index,
    input  logic [tpyp_pkg::BYTE_W-1:0]    entry_red,
    input  logic [tpyp_pkg::BYTE_W-1:0]    entry_green,
    input  logic [tpyp_pkg::BYTE_W-1:0]    entry_blue,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [tpyp_pkg::CH_W-1:0] luma,
    output logic signed [tpyp_pkg::CH_W-1:0] chroma_blue,
    output logic signed [tpyp_pkg::CH_W-1:0] chroma_red,
    output logic [tpyp_pkg::POS_OUT_W-1:0] column,
    output logic [tpyp_pkg::POS_OUT_W-1:0] row,
    output logic                           row_done
);
    import tpyp_pkg::*;

    logic                q_push, q_pop;
    cmd_t                q_cmd, q_head;
    logic [CQ_CNT_W-1:0] q_count;
    result_t             out_word;

    tpyp_front #(
        .TILE_SIZE     (TILE_SIZE),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .byte0       (byte0),
        .byte1       (byte1),
        .byte2       (byte2),
        .byte3       (byte3),
        .entry_index (entry_index),
        .entry_red   (entry_red),
        .entry_green (entry_green),
        .entry_blue  (entry_blue),
        .q_count     (q_count),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    tpyp_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .count    (q_count)
    );

    tpyp_back #(
        .TILE_SIZE (TILE_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_count   (q_count),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always_comb
    begin
        luma        = out_word.ycc.luma;
        chroma_blue = out_word.ycc.cb;
        chroma_red  = out_word.ycc.cr;
        column      = out_word.column;
        row         = out_word.row;
        row_done    = out_word.row_done;
    end

endmodule

`default_nettype wire
